// ===== rtl/ulp_distance_total_order_unit_assert.svh =====
// ----------------------------------------------------------------------------
// ulp_distance_total_order_unit_assert.svh
// Assertion macros for the ulp distance unit; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ULP_DISTANCE_TOTAL_ORDER_UNIT_ASSERT_SVH
`define ULP_DISTANCE_TOTAL_ORDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define ULDT_ASSERT_NOW(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ULDT_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("assertion failed");
`else
`define ULDT_ASSERT_NOW(lbl, ant, cons)
`define ULDT_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

// ===== rtl/uldt_pkg.sv =====
// ----------------------------------------------------------------------------
// uldt_pkg
// Shared types, codes and helpers of the ulp distance unit.
// ----------------------------------------------------------------------------
`default_nettype none
package uldt_pkg;
	localparam logic [1:0] OVR_NONE = 2'd0;
	localparam logic [1:0] OVR_ZERO = 2'd1;
	localparam logic [1:0] OVR_INF  = 2'd2;

	localparam logic [63:0] DBL_POS_INF = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] DBL_QNAN_BIT = 64'h0008_0000_0000_0000;
	localparam logic [10:0] EXP_MAX = 11'h7FF;

	localparam logic CFG_ELEMENT_FORMAT = 1'b0;
	localparam logic CFG_USE_RESIDUAL   = 1'b1;

	typedef struct packed {
		logic [1:0] ovr;
		logic       last;
	} ctl_t;

	// operands lined up for the adder
	typedef struct packed {
		logic        special;
		logic [63:0] spec_val;
		logic        sx;
		logic [10:0] ex;
		logic        sub;
		logic [55:0] sigx;
		logic [55:0] sigy;
	} align_t;

	// raw sum waiting for normalization
	typedef struct packed {
		logic        special;
		logic [63:0] spec_val;
		logic        sx;
		logic [10:0] ex;
		logic        zero;
		logic [56:0] sum;
		logic [5:0]  lz;
	} sum_t;

	// leading zero count, binary search in six steps; 64 for zero
	function automatic logic [6:0] lzc64(input logic [63:0] x);
		logic [63:0] v;
		logic [6:0]  n;
		v = x;
		n = 7'd0;
		if (v == 64'd0) begin
			n = 7'd64;
		end else begin
			if (v[63:32] == 32'd0) begin n = n + 7'd32; v = v << 32; end
			if (v[63:48] == 16'd0) begin n = n + 7'd16; v = v << 16; end
			if (v[63:56] == 8'd0)  begin n = n + 7'd8;  v = v << 8;  end
			if (v[63:60] == 4'd0)  begin n = n + 7'd4;  v = v << 4;  end
			if (v[63:62] == 2'd0)  begin n = n + 7'd2;  v = v << 2;  end
			if (v[63] == 1'b0)     begin n = n + 7'd1; end
		end
		return n;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/uldt_key.sv =====
// ----------------------------------------------------------------------------
// uldt_key
// Total-order keys of both operands, their difference and the override code.
// ----------------------------------------------------------------------------
`default_nettype none
module uldt_key (
	input  wire logic [63:0] cb,
	input  wire logic [63:0] rb,
	input  wire logic        wide,
	output logic      [63:0] diff,
	output logic      [1:0]  ovr
);
	logic [63:0] kc, kr;
	logic cn, ci, cs, rn, ri, rs;

	function automatic logic [63:0] key(input logic [63:0] b, input logic w);
		logic [31:0] k32;
		k32 = b[31] ? (32'h8000_0000 - b[31:0]) : b[31:0];
		if (w) begin
			return b[63] ? (64'h8000_0000_0000_0000 - b) : b;
		end
		return {{32{k32[31]}}, k32};
	endfunction

	always_comb begin
		kc = key(cb, wide);
		kr = key(rb, wide);
		diff = kc - kr;
		if (wide) begin
			cn = (cb[62:52] == 11'h7FF) && (cb[51:0] != 52'd0);
			ci = (cb[62:52] == 11'h7FF) && (cb[51:0] == 52'd0);
			cs = cb[63];
			rn = (rb[62:52] == 11'h7FF) && (rb[51:0] != 52'd0);
			ri = (rb[62:52] == 11'h7FF) && (rb[51:0] == 52'd0);
			rs = rb[63];
		end else begin
			cn = (cb[30:23] == 8'hFF) && (cb[22:0] != 23'd0);
			ci = (cb[30:23] == 8'hFF) && (cb[22:0] == 23'd0);
			cs = cb[31];
			rn = (rb[30:23] == 8'hFF) && (rb[22:0] != 23'd0);
			ri = (rb[30:23] == 8'hFF) && (rb[22:0] == 23'd0);
			rs = rb[31];
		end
		// mismatch wins over the agreeing cases
		if ((cn != rn) || (ci != ri) || (ci && ri && (cs != rs))) begin
			ovr = uldt_pkg::OVR_INF;
		end else if ((cn && rn) || (ci && ri)) begin
			ovr = uldt_pkg::OVR_ZERO;
		end else begin
			ovr = uldt_pkg::OVR_NONE;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/uldt_i2f.sv =====
// ----------------------------------------------------------------------------
// uldt_i2f
// Normalize a 64-bit magnitude and round it to a binary64 pattern.
// ----------------------------------------------------------------------------
`default_nettype none
module uldt_i2f (
	input  wire logic        sign,
	input  wire logic [63:0] mag,
	input  wire logic [5:0]  lz,
	output logic      [63:0] dbl
);
	logic [63:0] norm;
	logic        up;
	logic [10:0] expf;
	logic [62:0] packed_v;

	always_comb begin
		norm = mag << lz;
		up = norm[10] & ((|norm[9:0]) | norm[11]);
		expf = 11'd1086 - {5'd0, lz};
		// rounding carry ripples into the exponent
		packed_v = {expf, norm[62:11]} + {62'd0, up};
		dbl = (mag == 64'd0) ? 64'd0 : {sign, packed_v};
	end
endmodule
`default_nettype wire

// ===== rtl/uldt_align.sv =====
// ----------------------------------------------------------------------------
// uldt_align
// Unpack the two adder operands, order them by magnitude, align the smaller.
// ----------------------------------------------------------------------------
`default_nettype none
module uldt_align (
	input  wire logic [63:0]     a,
	input  wire logic [63:0]     b,
	output uldt_pkg::align_t     al
);
	logic        swap;
	logic [63:0] x, y;
	logic [10:0] ex_eff, ey_eff, d;
	logic [55:0] sigy, mask;

	always_comb begin
		swap = b[62:0] > a[62:0];
		x = swap ? b : a;
		y = swap ? a : b;
		ex_eff = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
		ey_eff = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
		d = ex_eff - ey_eff;
		sigy = {y[62:52] != 11'd0, y[51:0], 3'b000};
		mask = (56'd1 << d[5:0]) - 56'd1;

		al.special = (b[62:52] == uldt_pkg::EXP_MAX);
		al.spec_val = (b[51:0] != 52'd0) ? (b | uldt_pkg::DBL_QNAN_BIT) : b;
		al.sx = x[63];
		al.ex = ex_eff;
		al.sub = a[63] ^ b[63];
		al.sigx = {x[62:52] != 11'd0, x[51:0], 3'b000};
		if (d >= 11'd56) begin
			al.sigy = {55'd0, |sigy};
		end else begin
			al.sigy = (sigy >> d[5:0]);
			al.sigy[0] = al.sigy[0] | (|(sigy & mask));
		end
	end
endmodule
`default_nettype wire

// ===== rtl/uldt_norm_round.sv =====
// ----------------------------------------------------------------------------
// uldt_norm_round
// Normalize the adder sum, round to nearest even and pack binary64.
// ----------------------------------------------------------------------------
`default_nettype none
module uldt_norm_round (
	input  wire uldt_pkg::sum_t s,
	output logic [63:0]         dbl
);
	logic [55:0] n;
	logic [11:0] e;
	logic [5:0]  want, shl;
	logic [10:0] lim;
	logic        up;
	logic [10:0] expf;
	logic [62:0] packed_v;

	always_comb begin
		want = s.lz - 6'd1;
		lim = s.ex - 11'd1;
		shl = ({5'd0, want} < lim) ? want : lim[5:0];
		if (s.lz == 6'd0) begin
			// carry out: shift right one, fold the lost bit into sticky
			n = {s.sum[56:2], s.sum[1] | s.sum[0]};
			e = {1'b0, s.ex} + 12'd1;
		end else begin
			n = s.sum[55:0] << shl;
			e = {1'b0, s.ex} - {6'd0, shl};
		end
		up = n[2] & (n[1] | n[0] | n[3]);
		expf = n[55] ? e[10:0] : 11'd0;
		packed_v = {expf, n[54:3]} + {62'd0, up};
		if (s.special) begin
			dbl = s.spec_val;
		end else if (s.zero) begin
			dbl = 64'd0;
		end else if (e >= 12'd2047) begin
			dbl = {s.sx, uldt_pkg::DBL_POS_INF[62:0]};
		end else begin
			dbl = {s.sx, packed_v};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ulp_distance_total_order_unit.sv =====
// ----------------------------------------------------------------------------
// ulp_distance_total_order_unit
// Signed ulp distance of two IEEE values through total-order keys.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless out_ready holds the output, and returns one
// result word per input, in order. The seven register stages are: input, key
// difference, magnitude and leading-zero count, integer-to-double rounding,
// adder alignment, adder sum, normalize/round. All stages advance together;
// in_ready drops only while the output word is held by out_ready low. The user
// must write configuration only while no word is in flight; no check enforces it.
`default_nettype none
module ulp_distance_total_order_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] computed_bits,
	input  wire logic [63:0] reference_bits,
	input  wire logic [63:0] residual_bits,
	input  wire logic        last_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [63:0] error_bits,
	output logic             last_out
);
	`include "ulp_distance_total_order_unit_assert.svh"

	logic element_format_q, use_residual_q;
	logic [7:1] v_q;
	logic en;

	logic [63:0] cb_s1, rb_s1, res_s1;
	logic        last_s1;
	logic [63:0] diff_s2, res_s2;
	uldt_pkg::ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic        sign_s3;
	logic [63:0] mag_s3, res_s3;
	logic [5:0]  lz_s3;
	logic [63:0] a_s4, res_s4;
	uldt_pkg::align_t al_s5;
	uldt_pkg::sum_t   sum_s6;
	logic [63:0] err_s7;
	logic        last_s7;

	logic [63:0] diff_c, mag_c, dbl_c, nr_c, b_c;
	logic [1:0]  ovr_c;
	logic [6:0]  lz_c;
	uldt_pkg::align_t al_c;
	logic [56:0] sum_c;
	logic [6:0]  slz_c;

	assign en = !v_q[7] || out_ready;
	assign in_ready = en;
	assign out_valid = v_q[7];
	assign error_bits = err_s7;
	assign last_out = last_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_format_q <= 1'b1;
			use_residual_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uldt_pkg::CFG_ELEMENT_FORMAT: element_format_q <= cfg_data;
				uldt_pkg::CFG_USE_RESIDUAL:   use_residual_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[6:1], in_valid};
		end
	end

	uldt_key u_key (
		.cb   (cb_s1),
		.rb   (rb_s1),
		.wide (element_format_q),
		.diff (diff_c),
		.ovr  (ovr_c)
	);

	always_comb begin
		mag_c = diff_s2[63] ? (~diff_s2 + 64'd1) : diff_s2;
		lz_c = uldt_pkg::lzc64(mag_c);
	end

	uldt_i2f u_i2f (
		.sign (sign_s3),
		.mag  (mag_s3),
		.lz   (lz_s3),
		.dbl  (dbl_c)
	);

	assign b_c = use_residual_q ? res_s4 : 64'd0;

	uldt_align u_align (
		.a  (a_s4),
		.b  (b_c),
		.al (al_c)
	);

	always_comb begin
		sum_c = al_s5.sub ? ({1'b0, al_s5.sigx} - {1'b0, al_s5.sigy})
		                  : ({1'b0, al_s5.sigx} + {1'b0, al_s5.sigy});
		slz_c = uldt_pkg::lzc64({sum_c, 7'd0});
	end

	uldt_norm_round u_nr (
		.s   (sum_s6),
		.dbl (nr_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cb_s1 <= computed_bits;
			rb_s1 <= reference_bits;
			res_s1 <= residual_bits;
			last_s1 <= last_item;

			diff_s2 <= diff_c;
			res_s2 <= res_s1;
			ctl_s2 <= '{ovr: ovr_c, last: last_s1};

			sign_s3 <= diff_s2[63];
			mag_s3 <= mag_c;
			lz_s3 <= lz_c[5:0];
			res_s3 <= res_s2;
			ctl_s3 <= ctl_s2;

			a_s4 <= dbl_c;
			res_s4 <= res_s3;
			ctl_s4 <= ctl_s3;

			al_s5 <= al_c;
			ctl_s5 <= ctl_s4;

			sum_s6.special <= al_s5.special;
			sum_s6.spec_val <= al_s5.spec_val;
			sum_s6.sx <= al_s5.sx;
			sum_s6.ex <= al_s5.ex;
			sum_s6.zero <= (sum_c == 57'd0);
			sum_s6.sum <= sum_c;
			sum_s6.lz <= slz_c[5:0];
			ctl_s6 <= ctl_s5;

			unique case (ctl_s6.ovr)
				uldt_pkg::OVR_ZERO: err_s7 <= 64'd0;
				uldt_pkg::OVR_INF:  err_s7 <= uldt_pkg::DBL_POS_INF;
				default:            err_s7 <= nr_c;
			endcase
			last_s7 <= ctl_s6.last;
		end
	end

	`ULDT_ASSERT_NEXT(a_capture, in_valid && in_ready, v_q[1])
	`ULDT_ASSERT_NEXT(a_frozen, !en, $stable(v_q))
	`ULDT_ASSERT_NOW(a_no_neg_zero, v_q[4], a_s4 != 64'h8000_0000_0000_0000)
endmodule
`default_nettype wire

// ===== bench/ulp_distance_checker.sv =====
// ----------------------------------------------------------------------------
// ulp_distance_checker
// Watches the configuration port and both word channels of the ulp distance
// unit. It predicts the error word of each accepted input and compares it
// with the output words in order.
// ----------------------------------------------------------------------------
`default_nettype none
module ulp_distance_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [63:0] computed_bits,
	input  wire logic [63:0] reference_bits,
	input  wire logic [63:0] residual_bits,
	input  wire logic        last_item,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [63:0] error_bits,
	input  wire logic        last_out,
	output int               fail_count,
	output int               words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0] err;
		logic        last;
	} err_word_t;

	err_word_t   err_words[$];
	logic        fmt_wide;
	logic        add_residual;

	function automatic logic [63:0] order_key(logic [63:0] b, logic wide);
		logic [31:0] k;
		if (wide)
			return b[63] ? (64'h8000_0000_0000_0000 - b) : b;
		k = b[31] ? (32'h8000_0000 - b[31:0]) : b[31:0];
		return {{32{k[31]}}, k};
	endfunction

	// signed 64-bit integer to binary64, round to nearest even
	function automatic logic [63:0] key_to_double(logic [63:0] d);
		logic [63:0] m;
		logic [63:0] norm;
		logic [52:0] mant;
		logic [10:0] e;
		int          p;
		m = d[63] ? (~d + 64'd1) : d;
		if (m == 64'd0)
			return 64'd0;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (m[i]) p = i;
		norm = m << (63 - p);
		mant = {1'b0, norm[62:11]};
		e = 11'(1023 + p);
		if (norm[10] && ((|norm[9:0]) || mant[0])) begin
			mant = mant + 53'd1;
			if (mant[52]) e = e + 11'd1;
		end
		return {d[63], e, mant[51:0]};
	endfunction

	function automatic void classify(logic [63:0] b, logic wide,
			output logic is_nan, output logic is_inf, output logic neg);
		if (wide) begin
			is_nan = (b[62:52] == uldt_pkg::EXP_MAX) && (b[51:0] != 0);
			is_inf = (b[62:52] == uldt_pkg::EXP_MAX) && (b[51:0] == 0);
			neg = b[63];
		end else begin
			is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
			is_inf = (b[30:23] == 8'hFF) && (b[22:0] == 0);
			neg = b[31];
		end
	endfunction

	function automatic logic [63:0] predict_distance(logic [63:0] c, logic [63:0] r,
			logic [63:0] res, logic wide, logic use_res);
		logic [63:0] sum;
		logic        cn, ci, cs, rn, ri, rs;
		sum = key_to_double(order_key(c, wide) - order_key(r, wide));
		if (use_res) begin
			if (res[62:52] == uldt_pkg::EXP_MAX && res[51:0] != 0)
				sum = res | uldt_pkg::DBL_QNAN_BIT;
			else
				sum = $realtobits($bitstoreal(sum) + $bitstoreal(res));
		end
		classify(c, wide, cn, ci, cs);
		classify(r, wide, rn, ri, rs);
		if ((cn && rn) || (ci && ri && cs == rs))
			sum = 64'd0;
		if ((cn != rn) || (ci != ri) || (ci && ri && cs != rs))
			sum = uldt_pkg::DBL_POS_INF;
		return sum;
	endfunction

	assign words_pending = err_words.size();

	always @(posedge clk or negedge arst_n) begin
		err_word_t want;
		int        errs;
		errs = 0;
		if (!arst_n) begin
			fmt_wide <= 1'b1;
			add_residual <= 1'b0;
			fail_count <= 0;
			err_words.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == uldt_pkg::CFG_ELEMENT_FORMAT) fmt_wide <= cfg_data;
				else add_residual <= cfg_data;
			end
			if (in_valid && in_ready) begin
				want.err = predict_distance(computed_bits, reference_bits,
					residual_bits, fmt_wide, add_residual);
				want.last = last_item;
				err_words.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (err_words.size() == 0) begin
					$error("output word with none expected: error_bits %h", error_bits);
					errs++;
				end else begin
					want = err_words.pop_front();
					if (error_bits !== want.err) begin
						$error("error_bits: expected %h, actual %h", want.err, error_bits);
						errs++;
					end
					if (last_out !== want.last) begin
						$error("last_out: expected %b, actual %b", want.last, last_out);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the ulp distance unit.
// ----------------------------------------------------------------------------
// Runs four configuration phases (both formats, residual on and off), each
// with directed special values and random pairs, with random idling on both
// channels for part of them. The checker beside the block predicts and compares.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PER_PHASE = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] computed_bits = '0;
	logic [63:0] reference_bits = '0;
	logic [63:0] residual_bits = '0;
	logic        last_item = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] error_bits;
	logic        last_out;
	int          fail_count;
	int          words_pending;
	logic        no_idle = 1'b0;
	int          quiet_cycles = 0;

	ulp_distance_total_order_unit dut (.*);
	ulp_distance_checker chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog: cycles with no word accepted on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stall before each word
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 13);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic logic [63:0] pack_val(logic w, logic s, int e, logic [51:0] m);
		if (w)
			return {s, 11'(e), m};
		return {$urandom(), s, 8'(e), m[22:0]};
	endfunction

	function automatic logic [51:0] rand_man();
		return 52'({$urandom, $urandom});
	endfunction

	function automatic logic [63:0] rand_val(logic w);
		int emax;
		emax = w ? 2047 : 255;
		case ($urandom_range(0, 6))
			0: return pack_val(w, 1'($urandom), 0, '0);
			1: return pack_val(w, 1'($urandom), emax, '0);
			2: return pack_val(w, 1'($urandom), emax, rand_man() | 52'd1);
			3: return pack_val(w, 1'($urandom), 0, rand_man());
			4: return pack_val(w, 1'($urandom),
				$urandom_range(emax / 2 - 8, emax / 2 + 8), rand_man());
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] rand_residual();
		case ($urandom_range(0, 7))
			0: return {$urandom, $urandom};
			1: return pack_val(1'b1, 1'($urandom), 2047, rand_man() | 52'd1);
			2: return pack_val(1'b1, 1'($urandom), 2047, '0);
			3: return pack_val(1'b1, 1'($urandom), 0, '0);
			4: return pack_val(1'b1, 1'($urandom), $urandom_range(1080, 2046), rand_man());
			default: return pack_val(1'b1, 1'($urandom), $urandom_range(1000, 1030),
				rand_man());
		endcase
	endfunction

	task automatic send_word(logic [63:0] c, logic [63:0] r, logic [63:0] res, logic lst);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		computed_bits <= c;
		reference_bits <= r;
		residual_bits <= res;
		last_item <= lst;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic val);
		drain();
		repeat (12) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic fmt, logic use_res);
		logic [63:0] pz, nz, pinf, ninf, qnan, maxf, minf, one, r;
		logic [63:0] dres[4];
		write_reg(uldt_pkg::CFG_ELEMENT_FORMAT, fmt);
		write_reg(uldt_pkg::CFG_USE_RESIDUAL, use_res);
		pz = pack_val(fmt, 1'b0, 0, '0);
		nz = pack_val(fmt, 1'b1, 0, '0);
		pinf = pack_val(fmt, 1'b0, fmt ? 2047 : 255, '0);
		ninf = pack_val(fmt, 1'b1, fmt ? 2047 : 255, '0);
		qnan = pack_val(fmt, 1'b0, fmt ? 2047 : 255, '1);
		maxf = pack_val(fmt, 1'b0, fmt ? 2046 : 254, '1);
		minf = pack_val(fmt, 1'b1, fmt ? 2046 : 254, '1);
		one = pack_val(fmt, 1'b0, fmt ? 1023 : 127, '0);
		dres = '{64'h3FE0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF};
		// directed: signed zeros, non-finite pairs, extremes, residual corners
		no_idle <= 1'b1;
		send_word(pz, nz, dres[0], 1'b0);
		send_word(qnan, qnan | 64'd1, dres[1], 1'b1);
		send_word(qnan, one, dres[0], 1'b0);
		send_word(one, qnan, dres[0], 1'b0);
		send_word(pinf, pinf, dres[1], 1'b0);
		send_word(ninf, ninf, dres[0], 1'b1);
		send_word(pinf, ninf, dres[0], 1'b0);
		send_word(maxf, pinf, dres[0], 1'b0);
		send_word(pinf, qnan, dres[0], 1'b0);
		send_word(maxf, minf, dres[3], 1'b0);
		send_word(minf, maxf, dres[2], 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, dres[1], 1'b0);
		send_word(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, dres[2], 1'b1);
		send_word(one, pz, dres[3], 1'b0);
		no_idle <= 1'b0;
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			if (i % 40 == 0)
				no_idle <= ~no_idle;
			if (i == RANDOM_PER_PHASE / 2)
				drain();
			r = rand_val(fmt);
			if ($urandom_range(0, 2) == 0)
				send_word(r + 64'($signed($urandom_range(0, 40)) - 20), r,
					rand_residual(), 1'($urandom));
			else
				send_word(rand_val(fmt), r, rand_residual(), 1'($urandom));
		end
		no_idle <= 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_phase(1'b1, 1'b0);
		run_phase(1'b0, 1'b0);
		run_phase(1'b0, 1'b1);
		run_phase(1'b1, 1'b1);
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && words_pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
